[rtl/uks_pkg.sv]
// Shared types and constants for the unique key stack.
// Used by the channel interfaces, the core, the entry RAM instance and the checker.
package uks_pkg;

	localparam int DEPTH   = 64;
	localparam int KEY_W   = 32;
	localparam int COUNT_W = 7;
	localparam int ADDR_W  = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		CMD_PUSH   = 2'd0,
		CMD_POP    = 2'd1,
		CMD_SEARCH = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_DUP   = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_POP,
		S_RESP
	} state_t;

	typedef struct packed {
		cmd_t                    cmd;
		logic signed [KEY_W-1:0] key_in;
	} in_item_t;

	typedef struct packed {
		status_t                 status;
		logic signed [KEY_W-1:0] key_out;
		logic                    found;
		logic [COUNT_W-1:0]      count;
	} out_item_t;

endpackage

[rtl/uks_in_if.sv]
// Command channel of the unique key stack: valid/ready plus one command item.
// Depends on uks_pkg for the item type.
interface uks_in_if;
	import uks_pkg::*;

	logic     valid;
	logic     ready;
	in_item_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

[rtl/uks_out_if.sv]
// Result channel of the unique key stack: valid/ready plus one result item.
// Depends on uks_pkg for the item type.
interface uks_out_if;
	import uks_pkg::*;

	logic      valid;
	logic      ready;
	out_item_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

[rtl/uks_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module uks_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/unique_key_stack_core.sv]
// Unique key stack core: command channel in, result channel out, entries in uks_ram.
// Depends on uks_pkg, uks_in_if, uks_out_if and uks_ram.
//
// Bounded stack of DEPTH signed 32-bit keys that refuses full and duplicate pushes.
// One command is worked on at a time, and every command returns exactly one result
// that carries the count after the command. The duplicate check reads the stored
// entries one per cycle through the single read port of the entry RAM, and a hit
// ends the scan early. A pop does one RAM read. Clear, a push or search on an empty
// stack, a push to a full stack and a pop on an empty stack go straight to the result
// state with no scan. A finished result waits in an output register, and the next
// command is accepted while it waits. Entries hold no reset value; only data read
// from occupied entries is ever used.
module unique_key_stack_core (
	input logic  clk,
	input logic  arst_n,
	uks_in_if.sink    req,
	uks_out_if.source rsp
);
	import uks_pkg::*;

	state_t                  state_q, state_d;
	cmd_t                    cmd_q;
	logic signed [KEY_W-1:0] key_q;
	logic [CNT_W-1:0]        fill_q;
	logic [CNT_W-1:0]        idx_q;
	logic                    chk_vld_s1;
	logic                    chk_last_s1;
	out_item_t               res_q;
	out_item_t               out_q;
	logic                    out_valid_q;

	logic                    accept;
	logic                    issue;
	logic                    hit;
	logic                    scan_done;
	logic                    out_free;
	logic                    ram_we;
	logic [ADDR_W-1:0]       ram_waddr;
	logic [KEY_W-1:0]        ram_wdata;
	logic [ADDR_W-1:0]       ram_raddr;
	logic [KEY_W-1:0]        ram_rdata;
	logic [CNT_W-1:0]        fill_dec;
	logic [CNT_W-1:0]        fill_inc;
	logic                    is_full;
	logic                    is_empty;

	uks_ram #(
		.WIDTH(KEY_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign fill_dec = fill_q - CNT_W'(1);
	assign fill_inc = fill_q + CNT_W'(1);
	assign is_full  = (fill_q >= CNT_W'(DEPTH));
	assign is_empty = (fill_q == '0);
	assign out_free = !out_valid_q || rsp.ready;

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign rsp.valid = out_valid_q;
	assign rsp.item  = out_q;

	// compare stage sees the entry read in the previous cycle
	assign issue     = (state_q == S_SCAN) && (idx_q < fill_q);
	assign hit       = chk_vld_s1 && (ram_rdata == key_q);
	assign scan_done = hit || (chk_vld_s1 && chk_last_s1);

	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = fill_q[ADDR_W-1:0];
		ram_wdata = key_q;
		ram_raddr = idx_q[ADDR_W-1:0];
		case (state_q)
			S_IDLE: begin
				ram_raddr = fill_dec[ADDR_W-1:0];
				ram_wdata = req.item.key_in;
				if (accept) begin
					case (req.item.cmd)
						CMD_PUSH: begin
							if (is_full) begin
								state_d = S_RESP;
							end else if (is_empty) begin
								ram_we  = 1'b1;
								state_d = S_RESP;
							end else begin
								state_d = S_SCAN;
							end
						end
						CMD_POP: begin
							state_d = is_empty ? S_RESP : S_POP;
						end
						CMD_SEARCH: begin
							state_d = is_empty ? S_RESP : S_SCAN;
						end
						default: begin
							state_d = S_RESP;
						end
					endcase
				end
			end
			S_SCAN: begin
				if (scan_done) begin
					ram_we  = (cmd_q == CMD_PUSH) && !hit;
					state_d = S_RESP;
				end
			end
			S_POP: begin
				state_d = S_RESP;
			end
			S_RESP: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fill_q      <= '0;
			idx_q       <= '0;
			chk_vld_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_RESP && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					idx_q      <= '0;
					chk_vld_s1 <= 1'b0;
					if (accept) begin
						if (req.item.cmd == CMD_PUSH && !is_full && is_empty) begin
							fill_q <= CNT_W'(1);
						end else if (req.item.cmd == CMD_CLEAR) begin
							fill_q <= '0;
						end
					end
				end
				S_SCAN: begin
					chk_vld_s1 <= issue;
					if (issue) begin
						idx_q <= idx_q + CNT_W'(1);
					end
					if (scan_done && cmd_q == CMD_PUSH && !hit) begin
						fill_q <= fill_inc;
					end
				end
				S_POP: begin
					fill_q <= fill_dec;
				end
				default: begin
				end
			endcase
		end
	end

	// payload: no reset
	always_ff @(posedge clk) begin
		chk_last_s1 <= (idx_q == fill_dec);
		if (state_q == S_RESP && out_free) begin
			out_q <= res_q;
		end
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd_q         <= req.item.cmd;
					key_q         <= req.item.key_in;
					res_q.key_out <= '0;
					res_q.found   <= 1'b0;
					if (req.item.cmd == CMD_PUSH && is_full) begin
						res_q.status <= ST_FULL;
					end else if (req.item.cmd == CMD_POP && is_empty) begin
						res_q.status <= ST_EMPTY;
					end else begin
						res_q.status <= ST_OK;
					end
					if (req.item.cmd == CMD_CLEAR) begin
						res_q.count <= '0;
					end else if (req.item.cmd == CMD_PUSH && !is_full && is_empty) begin
						res_q.count <= COUNT_W'(1);
					end else begin
						res_q.count <= COUNT_W'(fill_q);
					end
				end
			end
			S_SCAN: begin
				if (scan_done) begin
					if (cmd_q == CMD_PUSH) begin
						if (hit) begin
							res_q.status <= ST_DUP;
						end else begin
							res_q.count <= COUNT_W'(fill_inc);
						end
					end else begin
						res_q.found <= hit;
					end
				end
			end
			S_POP: begin
				res_q.key_out <= ram_rdata;
				res_q.count   <= COUNT_W'(fill_dec);
			end
			default: begin
			end
		endcase
	end

endmodule

[rtl/uks_checker.sv]
// Port-level checks for the unique key stack core, attached by bind.
// Depends on uks_pkg; watches only the ports of unique_key_stack_core.
module uks_checker (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     req_valid,
	input logic                     req_ready,
	input logic                     rsp_valid,
	input logic                     rsp_ready,
	input uks_pkg::out_item_t       rsp_item
);
	import uks_pkg::*;

	// hold a stalled result
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
		else $error("result dropped or changed while stalled");

	// one command in flight: ready drops after every accepted item
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("command accepted while another is in progress");

	// a refused command returns no key and no hit
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_item.status != ST_OK |->
			rsp_item.key_out == '0 && !rsp_item.found)
		else $error("refused command carries key or found");

	// full refusal reports a full count, empty pop reports zero
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |->
			(rsp_item.status != ST_FULL || rsp_item.count == COUNT_W'(DEPTH)) &&
			(rsp_item.status != ST_EMPTY || rsp_item.count == '0))
		else $error("status and count disagree");

endmodule

bind unique_key_stack_core uks_checker u_uks_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req.valid),
	.req_ready(req.ready),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.rsp_item (rsp.item)
);

[bench/stack_checker.sv]
`timescale 1ns / 100ps
// Result checker for the unique key stack: watches both channels, predicts each result.
// Depends on uks_pkg, uks_in_if and uks_out_if.
module stack_checker (
	input logic         clk,
	input logic         arst_n,
	uks_in_if           req,
	uks_out_if          rsp,
	output int unsigned fail_count,
	output int unsigned outstanding
);
	import uks_pkg::*;

	logic signed [KEY_W-1:0] stored_keys [DEPTH];
	int unsigned             stored_fill;
	out_item_t               expected_results [$];
	int unsigned             results_seen;

	function automatic bit key_stored(logic signed [KEY_W-1:0] key);
		for (int i = 0; i < stored_fill; i++) begin
			if (stored_keys[i] == key) begin
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic out_item_t apply_stack_op(in_item_t op);
		out_item_t r;
		r.status  = ST_OK;
		r.key_out = '0;
		r.found   = 1'b0;
		case (op.cmd)
			CMD_PUSH: begin
				// full wins over duplicate
				if (stored_fill >= DEPTH) begin
					r.status = ST_FULL;
				end else if (key_stored(op.key_in)) begin
					r.status = ST_DUP;
				end else begin
					stored_keys[stored_fill] = op.key_in;
					stored_fill++;
				end
			end
			CMD_POP: begin
				if (stored_fill == 0) begin
					r.status = ST_EMPTY;
				end else begin
					stored_fill--;
					r.key_out = stored_keys[stored_fill];
				end
			end
			CMD_SEARCH: begin
				r.found = key_stored(op.key_in);
			end
			default: begin
				stored_fill = 0;
			end
		endcase
		r.count = COUNT_W'(stored_fill);
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		$display("mismatch at %0t: result %0d: %s", $realtime, results_seen, msg);
		fail_count++;
	endtask

	always @(posedge clk) begin : watch
		out_item_t want;
		out_item_t got;
		if (arst_n) begin
			// retire the result before queuing a new prediction
			if (rsp.valid && rsp.ready) begin
				got = rsp.item;
				results_seen++;
				if (expected_results.size() == 0) begin
					report_mismatch("result arrived with nothing expected");
				end else begin
					want = expected_results.pop_front();
					if (got.status !== want.status)
						report_mismatch($sformatf("status expected %0d got %0d",
							want.status, got.status));
					if (got.key_out !== want.key_out)
						report_mismatch($sformatf("key_out expected %0d got %0d",
							want.key_out, got.key_out));
					if (got.found !== want.found)
						report_mismatch($sformatf("found expected %0d got %0d",
							want.found, got.found));
					if (got.count !== want.count)
						report_mismatch($sformatf("count expected %0d got %0d",
							want.count, got.count));
				end
			end
			if (req.valid && req.ready) begin
				expected_results.push_back(apply_stack_op(req.item));
			end
		end
		outstanding = expected_results.size();
	end

endmodule

[bench/testbench.sv]
`timescale 1ns / 100ps
// Top of the unique key stack bench: clock, reset, command stimulus and receiver stalls.
// Depends on uks_pkg, the channel interfaces, unique_key_stack_core and stack_checker.
module testbench;
	import uks_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_CYCLES    = 400;
	localparam int RANDOM_ITEMS   = 950;

	logic                    clk;
	logic                    arst_n;
	int unsigned             fail_count;
	int unsigned             outstanding;
	int unsigned             items_sent;
	int unsigned             burst_left;
	int unsigned             hold_requests;
	int unsigned             idle_cycles;
	logic signed [KEY_W-1:0] recent_keys [$];

	uks_in_if  req_ch ();
	uks_out_if rsp_ch ();

	unique_key_stack_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	stack_checker stack_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// receiver: random stall patterns; long hold-off on request
	initial begin : receiver
		int unsigned cycle_no;
		int unsigned hold_left;
		int unsigned holds_served;
		int          mode;
		cycle_no     = 0;
		hold_left    = 0;
		holds_served = 0;
		mode         = 0;
		rsp_ch.ready <= 1'b0;
		@(posedge clk);
		forever begin
			@(negedge clk);
			cycle_no++;
			if (cycle_no % 128 == 0)
				mode = $urandom_range(0, 3);
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else if (holds_served != hold_requests) begin
				holds_served++;
				hold_left = HOLD_CYCLES;
				rsp_ch.ready <= 1'b0;
			end else begin
				case (mode)
					0: rsp_ch.ready <= 1'b1;
					1: rsp_ch.ready <= 1'($urandom_range(0, 1));
					2: rsp_ch.ready <= (cycle_no % 3 == 0);
					default: rsp_ch.ready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_op(cmd_t c, logic signed [KEY_W-1:0] key);
		in_item_t it;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			if ($urandom_range(0, 3) != 0) begin
				req_ch.valid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(negedge clk);
			end
		end
		it.cmd    = c;
		it.key_in = key;
		req_ch.valid <= 1'b1;
		req_ch.item  <= it;
		do @(posedge clk); while (!req_ch.ready);
		@(negedge clk);
		burst_left--;
		items_sent++;
		if (c == CMD_PUSH) begin
			recent_keys.push_back(key);
			if (recent_keys.size() > 96)
				void'(recent_keys.pop_front());
		end
	endtask

	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		burst_left = 0;
		do @(negedge clk); while (outstanding != 0);
	endtask

	// Often keys seen before, so duplicates and search hits are common.
	function automatic logic signed [KEY_W-1:0] pick_key();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 45 && recent_keys.size() > 0)
			return recent_keys[$urandom_range(0, recent_keys.size() - 1)];
		if (r < 55) begin
			case ($urandom_range(0, 3))
				0: return 32'h8000_0000;
				1: return 32'h7fff_ffff;
				2: return 32'h0000_0000;
				default: return 32'hffff_ffff;
			endcase
		end
		return $urandom;
	endfunction

	function automatic cmd_t pick_cmd();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return CMD_PUSH;
		if (r < 65)
			return CMD_POP;
		if (r < 95)
			return CMD_SEARCH;
		return CMD_CLEAR;
	endfunction

	// Push enough fresh keys to fill from any count, then hit the full cases and unwind.
	task automatic run_fill();
		repeat ($urandom_range(66, 72)) send_op(CMD_PUSH, $urandom);
		send_op(CMD_PUSH, recent_keys[recent_keys.size() - 1]);
		repeat (2) send_op(CMD_PUSH, pick_key());
		repeat (3) send_op(CMD_SEARCH, pick_key());
		repeat ($urandom_range(1, 70)) send_op(CMD_POP, $urandom);
	endtask

	initial begin : stimulus
		int unsigned seg_kind;
		bit          hold_issued;
		hold_issued = 1'b0;
		burst_left  = 0;
		arst_n      = 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.item  <= '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// empty stack corners, field extremes, duplicates and unwinding
		send_op(CMD_POP, $urandom);
		send_op(CMD_SEARCH, 32'h0000_0000);
		send_op(CMD_CLEAR, $urandom);
		send_op(CMD_PUSH, 32'h8000_0000);
		send_op(CMD_PUSH, 32'h7fff_ffff);
		send_op(CMD_PUSH, 32'h0000_0000);
		send_op(CMD_PUSH, 32'hffff_ffff);
		send_op(CMD_PUSH, 32'h5555_5555);
		send_op(CMD_PUSH, 32'haaaa_aaaa);
		send_op(CMD_PUSH, 32'h7fff_ffff);
		send_op(CMD_PUSH, 32'h8000_0000);
		send_op(CMD_SEARCH, 32'h8000_0000);
		send_op(CMD_SEARCH, 32'hffff_ffff);
		send_op(CMD_SEARCH, 32'h0000_0001);
		send_op(CMD_POP, $urandom);
		send_op(CMD_POP, $urandom);
		send_op(CMD_SEARCH, 32'h5555_5555);
		send_op(CMD_CLEAR, $urandom);
		send_op(CMD_POP, $urandom);
		send_op(CMD_PUSH, 32'h0000_0001);
		send_op(CMD_SEARCH, 32'h0000_0001);
		send_op(CMD_POP, $urandom);

		run_fill();
		while (items_sent < RANDOM_ITEMS) begin
			// block the result side once while commands keep coming
			if (!hold_issued && items_sent > 400) begin
				hold_requests++;
				hold_issued = 1'b1;
				seg_kind    = 0;
			end else begin
				seg_kind = $urandom_range(0, 9);
			end
			case (seg_kind)
				5: run_fill();
				6: repeat ($urandom_range(10, 70)) send_op(CMD_POP, $urandom);
				7: repeat ($urandom_range(5, 30)) send_op(CMD_SEARCH, pick_key());
				8: begin
					send_op(CMD_CLEAR, $urandom);
					repeat ($urandom_range(1, 20)) send_op(CMD_PUSH, pick_key());
				end
				9: begin
					wait_drained();
					repeat ($urandom_range(10, 60)) send_op(pick_cmd(), pick_key());
				end
				default: repeat ($urandom_range(10, 60)) send_op(pick_cmd(), pick_key());
			endcase
		end

		wait_drained();
		repeat (80) @(negedge clk);
		if (fail_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
